// ----- hw/rtl/psd_pkg.sv -----
// Shared constants for the pour session detector: field widths, request and
// event codes, configuration register indexes and their reset values.
// No dependencies.
package psd_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned EventW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned FracW  = 16;

  // Request codes carried by req_type.
  localparam logic [ReqW-1:0] ReqTick = 2'd0;
  localparam logic [ReqW-1:0] ReqPoll = 2'd1;
  localparam logic [ReqW-1:0] ReqEnd  = 2'd2;

  // Event codes carried by event_res.
  localparam logic [EventW-1:0] EvNone    = 2'd0;
  localparam logic [EventW-1:0] EvStart   = 2'd1;
  localparam logic [EventW-1:0] EvReport  = 2'd2;
  localparam logic [EventW-1:0] EvDiscard = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdleTimeout   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxDuration   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinPour       = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgVolumePerTick = 2'd3;

  // Configuration reset values.
  localparam logic [DataW-1:0] IdleTimeoutReset   = 32'd2000;
  localparam logic [DataW-1:0] MaxDurationReset   = 32'd0;
  localparam logic [DataW-1:0] MinPourReset       = 32'd0;
  localparam logic [DataW-1:0] VolumePerTickReset = 32'd65536;

endpackage

// ----- hw/rtl/psd_if.sv -----
// Valid/ready channel interfaces for the pour session detector: the request
// channel and the result channel. Depends on psd_pkg.
interface psd_req_if import psd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ReqW-1:0]   req_type;
  logic [DataW-1:0]  tick_count;
  logic [DataW-1:0]  now_time;
  logic [DataW-1:0]  wall_time;

  modport source (output valid, output req_type, output tick_count,
                  output now_time, output wall_time, input ready);
  modport sink   (input valid, input req_type, input tick_count,
                  input now_time, input wall_time, output ready);
endinterface

interface psd_res_if import psd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_res;
  logic [DataW-1:0]  pour_ticks;
  logic [DataW-1:0]  pour_volume;
  logic [DataW-1:0]  pour_start_wall;
  logic [DataW-1:0]  pour_duration;
  logic [DataW-1:0]  lifetime_ticks;

  modport source (output valid, output event_res, output pour_ticks,
                  output pour_volume, output pour_start_wall,
                  output pour_duration, output lifetime_ticks, input ready);
  modport sink   (input valid, input event_res, input pour_ticks,
                  input pour_volume, input pour_start_wall,
                  input pour_duration, input lifetime_ticks, output ready);
endinterface

// ----- hw/rtl/pour_session_detector.sv -----
// Top level of the pour session detector: session state, event decision
// and the volume multiplier. Depends on psd_pkg and the interfaces in psd_if.
//
// Usage:
//   Requests arrive on the req channel (tick report, poll, end pour); each
//   accepted request yields exactly one res transaction, in order. The four
//   configuration registers are written through cfg_we / cfg_index /
//   cfg_data; the user must do so only while the block is idle (unenforced).
// Pipeline and throughput:
//   Session state is updated at the edge that accepts a request, so the next
//   request sees it at once. The result passes a decision register and then
//   the volume multiply (32 x 32 bits, saturated) into the output register,
//   from which it is offered on res. One request per cycle is accepted
//   while res.ready does not stall the output.
// Reset:
//   rst clears the session, the lifetime count, the pipeline valid bits and
//   loads the configuration defaults.
// Stall:
//   When res.ready is low the output register holds its result; the decision
//   register still takes one more request, after which req.ready drops.
module pour_session_detector import psd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data,
  psd_req_if.sink            req,
  psd_res_if.source          res
);

  typedef struct packed {
    logic [EventW-1:0] ev;
    logic [DataW-1:0]  ticks;
    logic [DataW-1:0]  start_wall;
    logic [DataW-1:0]  duration;
    logic [DataW-1:0]  lifetime;
  } decision_t;

  // Configuration registers.
  logic [DataW-1:0] idle_timeout;
  logic [DataW-1:0] max_duration;
  logic [DataW-1:0] min_pour;
  logic [DataW-1:0] volume_per_tick;

  // Session state.
  logic             pouring;
  logic [DataW-1:0] session_count;
  logic [DataW-1:0] total_count;
  logic [DataW-1:0] start_time;
  logic [DataW-1:0] start_wall;
  logic [DataW-1:0] last_tick_time;

  logic             pouring_next;
  logic [DataW-1:0] session_count_next;
  logic [DataW-1:0] total_count_next;
  logic [DataW-1:0] start_time_next;
  logic [DataW-1:0] start_wall_next;
  logic [DataW-1:0] last_tick_time_next;

  // Pipeline registers.
  logic      dec_valid;
  decision_t dec;
  decision_t dec_next;
  logic      out_valid;

  logic in_fire;
  logic dec_advance;
  logic close_now;
  logic idle_hit;
  logic long_hit;

  logic [2*DataW-1:0] product;
  logic [DataW-1:0]   volume_sat;

  assign dec_advance = !out_valid || res.ready;
  assign req.ready   = !dec_valid || dec_advance;
  assign in_fire     = req.valid && req.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout    <= IdleTimeoutReset;
      max_duration    <= MaxDurationReset;
      min_pour        <= MinPourReset;
      volume_per_tick <= VolumePerTickReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgIdleTimeout:   idle_timeout    <= cfg_data;
        CfgMaxDuration:   max_duration    <= cfg_data;
        CfgMinPour:       min_pour        <= cfg_data;
        CfgVolumePerTick: volume_per_tick <= cfg_data;
        default: ;
      endcase
    end
  end

  // Timeout checks for a poll; differences wrap modulo 2^32.
  assign idle_hit = (req.now_time - last_tick_time) >= idle_timeout;
  assign long_hit = (max_duration != '0) &&
                    ((req.now_time - start_time) >= max_duration);

  // Session update and event decision for the request at the port.
  always_comb begin
    pouring_next        = pouring;
    session_count_next  = session_count;
    total_count_next    = total_count;
    start_time_next     = start_time;
    start_wall_next     = start_wall;
    last_tick_time_next = last_tick_time;
    close_now           = 1'b0;
    dec_next            = '0;

    unique case (req.req_type)
      ReqTick: begin
        if (req.tick_count != '0) begin
          total_count_next    = total_count + req.tick_count;
          last_tick_time_next = req.now_time;
          if (!pouring) begin
            pouring_next       = 1'b1;
            start_time_next    = req.now_time;
            start_wall_next    = req.wall_time;
            session_count_next = req.tick_count;
            dec_next.ev        = EvStart;
          end else begin
            session_count_next = session_count + req.tick_count;
          end
        end
      end
      ReqPoll: close_now = pouring && (idle_hit || long_hit);
      ReqEnd:  close_now = pouring;
      default: ;
    endcase

    // A closed session is either reported or discarded as too small.
    if (close_now) begin
      pouring_next       = 1'b0;
      session_count_next = '0;
      if (session_count < min_pour) begin
        dec_next.ev = EvDiscard;
      end else begin
        dec_next.ev         = EvReport;
        dec_next.ticks      = session_count;
        dec_next.start_wall = start_wall;
        dec_next.duration   = last_tick_time - start_time;
      end
    end

    dec_next.lifetime = total_count_next;
  end

  // Session state registers advance on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      pouring        <= 1'b0;
      session_count  <= '0;
      total_count    <= '0;
      start_time     <= '0;
      start_wall     <= '0;
      last_tick_time <= '0;
    end else if (in_fire) begin
      pouring        <= pouring_next;
      session_count  <= session_count_next;
      total_count    <= total_count_next;
      start_time     <= start_time_next;
      start_wall     <= start_wall_next;
      last_tick_time <= last_tick_time_next;
    end
  end

  // Decision register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (req.ready) begin
      dec_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dec <= dec_next;
    end
  end

  // Volume in Q16.16 scaled back to whole milliliters, saturated to 32 bits.
  // Ticks are zero for every event except a report, so the volume is too.
  assign product    = dec.ticks * volume_per_tick;
  assign volume_sat = (product[2*DataW-1:DataW+FracW] != '0) ? '1
                                                              : product[DataW+FracW-1:FracW];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dec_advance) begin
      out_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_advance && dec_valid) begin
      res.event_res       <= dec.ev;
      res.pour_ticks      <= dec.ticks;
      res.pour_volume     <= volume_sat;
      res.pour_start_wall <= dec.start_wall;
      res.pour_duration   <= dec.duration;
      res.lifetime_ticks  <= dec.lifetime;
    end
  end

  assign res.valid = out_valid;

endmodule
